[rtl/f32fma_pkg.sv]
// ----------------------------------------------------------------------------
// f32fma_pkg
// Types, constants and helper functions for the single-precision fused
// multiply-add pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package f32fma_pkg;

    localparam int unsigned FW = 32;

    localparam logic [31:0] QNAN_DEFAULT = 32'hFFC0_0000;
    localparam logic [31:0] INF_BITS     = 32'h7F80_0000;
    localparam logic [31:0] QUIET_BIT    = 32'h0040_0000;

    typedef logic signed [11:0] t_exp;

    // Position of the highest set bit; zero for a zero word.
    function automatic logic [5:0] top_bit64(input logic [63:0] x);
        logic [5:0] p;
        p = 6'd0;
        for (int i = 0; i < 64; i++) begin
            if (x[i]) begin
                p = 6'(i);
            end
        end
        return p;
    endfunction

endpackage

`default_nettype wire

[rtl/float32_fused_multiply_add.sv]
// ----------------------------------------------------------------------------
// float32_fused_multiply_add
// Single-precision a*b+c with one rounding to nearest even, six-stage pipeline.
// Throughput: one transaction per cycle while the pipeline advances. The input
// register feeds the multiply, product normalise, align-and-add, leading-one
// search and round stages, and the round stage feeds the output register.
// The whole pipeline advances whenever the output register is empty or taken.
// Reset (synchronous, active low) clears all stage valid flags only.
// ----------------------------------------------------------------------------
`default_nettype none

module float32_fused_multiply_add (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [95:0] s_axis_tdata,  // a_value [31:0], b_value [63:32], c_value [95:64]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata   // sum_value [31:0]
);
    import f32fma_pkg::*;

    logic en;
    logic [5:0] r_v;

    assign en            = !r_v[5] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = r_v[5];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[4:0], s_axis_tvalid};
        end
    end

    // Stage 0: input register.
    logic [31:0] r_a, r_b, r_c;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a <= s_axis_tdata[31:0];
            r_b <= s_axis_tdata[63:32];
            r_c <= s_axis_tdata[95:64];
        end
    end

    // Stage 1: specials and significand product.
    logic [23:0] ma, mb, mc;
    logic [7:0]  xa, xb, xc;
    logic        nan_a, nan_b, nan_c, inf_a, inf_b, inf_c, sp, sc;
    logic [47:0] n_prod;
    logic        n_spec1;
    logic [31:0] n_sval1;

    always_comb begin
        ma = {r_a[30:23] != 8'd0, r_a[22:0]};
        mb = {r_b[30:23] != 8'd0, r_b[22:0]};
        mc = {r_c[30:23] != 8'd0, r_c[22:0]};
        xa = (r_a[30:23] != 8'd0) ? r_a[30:23] : 8'd1;
        xb = (r_b[30:23] != 8'd0) ? r_b[30:23] : 8'd1;
        xc = (r_c[30:23] != 8'd0) ? r_c[30:23] : 8'd1;
        nan_a = (r_a[30:23] == 8'hFF) && (r_a[22:0] != 23'd0);
        nan_b = (r_b[30:23] == 8'hFF) && (r_b[22:0] != 23'd0);
        nan_c = (r_c[30:23] == 8'hFF) && (r_c[22:0] != 23'd0);
        inf_a = (r_a[30:0] == INF_BITS[30:0]);
        inf_b = (r_b[30:0] == INF_BITS[30:0]);
        inf_c = (r_c[30:0] == INF_BITS[30:0]);
        sp = r_a[31] ^ r_b[31];
        sc = r_c[31];
        n_prod = ma * mb;
        n_spec1 = 1'b1;
        n_sval1 = '0;
        priority if (nan_a) begin
            n_sval1 = r_a | QUIET_BIT;
        end else if (nan_b) begin
            n_sval1 = r_b | QUIET_BIT;
        end else if (nan_c) begin
            n_sval1 = r_c | QUIET_BIT;
        end else if ((inf_a && mb == 24'd0) || (inf_b && ma == 24'd0)) begin
            n_sval1 = QNAN_DEFAULT;
        end else if (inf_a || inf_b) begin
            n_sval1 = (inf_c && sc != sp) ? QNAN_DEFAULT : ({sp, 31'd0} | INF_BITS);
        end else if (inf_c) begin
            n_sval1 = r_c;
        end else if (n_prod == 48'd0) begin
            n_sval1 = (mc == 24'd0) ? {sp & sc, 31'd0} : r_c;
        end else begin
            n_spec1 = 1'b0;
        end
    end

    logic        r1_spec, r1_sp, r1_sc;
    logic [31:0] r1_sval;
    logic [47:0] r1_prod;
    logic [23:0] r1_mc;
    t_exp        r1_ep, r1_ec;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_spec <= n_spec1;
            r1_sval <= n_sval1;
            r1_prod <= n_prod;
            r1_mc   <= mc;
            r1_sp   <= sp;
            r1_sc   <= sc;
            r1_ep   <= t_exp'({4'd0, xa}) + t_exp'({4'd0, xb}) - t_exp'(300);
            r1_ec   <= t_exp'({4'd0, xc}) - t_exp'(150);
        end
    end

    // Stage 2: normalise product and addend to bit 61.
    logic [5:0]  pp, pc;
    logic [63:0] n_xp, n_xc;
    t_exp        n_ep2, n_ec2;
    always_comb begin
        pp = top_bit64({16'd0, r1_prod});
        pc = top_bit64({40'd0, r1_mc});
        n_xp  = {16'd0, r1_prod} << (6'd61 - pp);
        n_xc  = {40'd0, r1_mc} << (6'd61 - pc);
        n_ep2 = r1_ep - t_exp'({6'd0, 6'd61 - pp});
        n_ec2 = r1_ec - t_exp'({6'd0, 6'd61 - pc});
    end

    logic        r2_spec, r2_sp, r2_sc, r2_czero;
    logic [31:0] r2_sval;
    logic [63:0] r2_xp, r2_xc;
    t_exp        r2_ep, r2_ec;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_spec  <= r1_spec;
            r2_sval  <= r1_sval;
            r2_sp    <= r1_sp;
            r2_sc    <= r1_sc;
            r2_czero <= (r1_mc == 24'd0);
            r2_xp    <= n_xp;
            r2_xc    <= n_xc;
            r2_ep    <= n_ep2;
            r2_ec    <= n_ec2;
        end
    end

    // Stage 3: align the smaller operand with sticky and add.
    logic [63:0] xbig, xsml, sm, n_r3;
    t_exp        ebig, esml, dd, n_eb3;
    logic        n_rs3, pbig, n_spec3;
    logic [31:0] n_sval3;
    always_comb begin
        pbig = (r2_ep > r2_ec) || (r2_ep == r2_ec && r2_xp >= r2_xc);
        xbig = pbig ? r2_xp : r2_xc;
        xsml = pbig ? r2_xc : r2_xp;
        ebig = pbig ? r2_ep : r2_ec;
        esml = pbig ? r2_ec : r2_ep;
        dd   = ebig - esml;
        if (dd >= t_exp'(63)) begin
            sm = 64'd1;
        end else begin
            sm = (xsml >> dd[5:0])
               | {63'd0, (xsml & ~({64{1'b1}} << dd[5:0])) != 64'd0};
        end
        n_spec3 = r2_spec;
        n_sval3 = r2_sval;
        if (r2_czero) begin
            n_r3  = r2_xp;
            n_eb3 = r2_ep;
            n_rs3 = r2_sp;
        end else begin
            n_r3  = (r2_sp == r2_sc) ? xbig + sm : xbig - sm;
            n_eb3 = ebig;
            n_rs3 = pbig ? r2_sp : r2_sc;
            if (!r2_spec && n_r3 == 64'd0) begin
                n_spec3 = 1'b1;
                n_sval3 = '0;
            end
        end
    end

    logic        r3_spec, r3_rs;
    logic [31:0] r3_sval;
    logic [63:0] r3_r;
    t_exp        r3_eb;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_spec <= n_spec3;
            r3_sval <= n_sval3;
            r3_r    <= n_r3;
            r3_eb   <= n_eb3;
            r3_rs   <= n_rs3;
        end
    end

    // Stage 4: leading-one position, biased exponent and rounding shift.
    logic [5:0] p4;
    t_exp       n_be4, n_s4;
    always_comb begin
        p4    = top_bit64(r3_r);
        n_be4 = t_exp'({6'd0, p4}) + r3_eb + t_exp'(127);
        n_s4  = (n_be4 < t_exp'(1)) ? (t_exp'(-149) - r3_eb)
                                    : (t_exp'({6'd0, p4}) - t_exp'(23));
    end

    logic        r4_spec, r4_rs;
    logic [31:0] r4_sval;
    logic [63:0] r4_r;
    t_exp        r4_be, r4_s;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_spec <= r3_spec;
            r4_sval <= r3_sval;
            r4_r    <= r3_r;
            r4_rs   <= r3_rs;
            r4_be   <= n_be4;
            r4_s    <= n_s4;
        end
    end

    // Stage 5: round to nearest even and pack.
    logic [63:0] q, rem, half, val;
    t_exp        beff, nsh;
    logic [31:0] n_out;
    always_comb begin
        nsh  = -r4_s;
        rem  = '0;
        half = '0;
        if (r4_s <= t_exp'(0)) begin
            q = r4_r << nsh[5:0];
        end else if (r4_s >= t_exp'(64)) begin
            q = '0;
        end else begin
            q    = r4_r >> r4_s[5:0];
            rem  = r4_r & ~({64{1'b1}} << r4_s[5:0]);
            half = 64'd1 << (r4_s[5:0] - 6'd1);
            if (rem > half || (rem == half && q[0])) begin
                q = q + 64'd1;
            end
        end
        beff = (r4_be < t_exp'(1)) ? t_exp'(1) : r4_be;
        val  = ({{52{1'b0}}, beff - t_exp'(1)} << 23) + q;
        if (val >= {32'd0, INF_BITS}) begin
            val = {32'd0, INF_BITS};
        end
        n_out = r4_spec ? r4_sval : {r4_rs, val[30:0]};
    end

    logic [31:0] r_out;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end
    assign m_axis_tdata = r_out;

endmodule

`default_nettype wire

[rtl/f32fma_checker.sv]
// ----------------------------------------------------------------------------
// f32fma_checker
// Port-level checks on the fused multiply-add pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module f32fma_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata
);

    a_no_out_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid) else $error("result valid after reset");

    a_ready_follows_sink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tready |-> s_axis_tready) else $error("input stalled with free output");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_idle_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tvalid && s_axis_tready) && !m_axis_tvalid && m_axis_tready
        ##1 !(s_axis_tvalid && s_axis_tready) && m_axis_tready
        ##1 !(s_axis_tvalid && s_axis_tready) && m_axis_tready
        ##1 !(s_axis_tvalid && s_axis_tready) && m_axis_tready
        ##1 !(s_axis_tvalid && s_axis_tready) && m_axis_tready
        ##1 !(s_axis_tvalid && s_axis_tready) && m_axis_tready
        |=> !m_axis_tvalid) else $error("result without transaction");

endmodule

bind float32_fused_multiply_add f32fma_checker u_f32fma_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
